>>> src/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define BPA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> src/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int unsigned MaxPages = 4096;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_UNALIGN  = 3'd2,
    ST_ZERO     = 3'd3,
    ST_BELOW    = 3'd4,
    ST_BEYOND   = 3'd5
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  localparam int unsigned CfgIdxBase  = 0;
  localparam int unsigned CfgIdxCount = 1;

  typedef struct packed {
    logic [0:0]  op;
    logic [12:0] n_pages;
    logic [47:0] free_address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] address;
    logic [11:0] page_index;
    logic [12:0] allocated_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SRD,
    S_SCAN,
    S_MRD,
    S_MARK,
    S_HRD,
    S_HSCAN,
    S_ADDR,
    S_FCHK,
    S_FRD,
    S_FREE,
    S_DONE
  } state_e;

endpackage

>>> src/bitmap_page_allocator.sv
// Channel | Dir | Handshake               | Payload
// req     | in  | req_valid_i/req_ready_o | req_i (op, n_pages, free_address)
// rsp     | out | rsp_valid_o/rsp_ready_i | rsp_o (status, address, page_index, count)
// cfg     | in  | cfg_we_i                | cfg_idx_i, cfg_data_i
// One item at a time; each page visited takes a memory read, then a test or a write.
// Allocate: scan from the hint for the first free run of n_pages, mark each page of
// that run, and if the run began at the hint, search on from its end for a new hint.
// Free: check the request, then clear each page of the range; rejected items end early.
// After reset a clearing pass zeroes every bitmap word before items are taken.
// The result register holds while rsp_ready_i is low; next item waits for it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned WORD_BITS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i
);

  localparam int unsigned NWORDS = (MaxPages + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned BW     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned PW     = $clog2(PAGE_BYTES);
  localparam int unsigned IW     = $clog2(NWORDS * WORD_BITS) + 1;

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rd_q;
  logic                 we;
  logic [AW-1:0]        wa, ra;
  logic [WORD_BITS-1:0] wd;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  logic [47:0] base_q;
  logic [12:0] npg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      npg_q  <= 13'd4096;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 1'(CfgIdxBase)) base_q <= cfg_data_i;
      else npg_q <= cfg_data_i[12:0];
    end
  end

  logic [IW-1:0] eff;
  assign eff = ({3'b0, npg_q} > 16'(MaxPages)) ? IW'(MaxPages) : IW'(npg_q);

  state_e st_q, st_d;
  logic [IW-1:0] ptr_q, ptr_d, first_q, first_d, run_q, run_d, end_q, end_d;
  logic [12:0] hint_q, hint_d, used_q, used_d, cnt_q, cnt_d;
  logic        op_q, op_d;
  logic [47:0] fa_q, fa_d;
  rsp_t        rsp_q, rsp_d;
  logic        rv_q, rv_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [47:0] diff;
  logic [47:0] sp;
  logic        bit_used;
  logic [13:0] used_sum;

  assign diff     = fa_q - base_q;
  assign sp       = diff >> PW;
  assign bit_used = rd_q[ptr_q[BW-1:0]];
  assign used_sum = {1'b0, used_q} + {1'b0, cnt_q};

  always_comb begin
    st_d = st_q; ptr_d = ptr_q; first_d = first_q; run_d = run_q; end_d = end_q;
    hint_d = hint_q; used_d = used_q; cnt_d = cnt_q; op_d = op_q; fa_d = fa_q;
    rsp_d = rsp_q; rv_d = rv_q; clr_d = clr_q;
    we = 1'b0; wa = ptr_q[BW +: AW]; wd = rd_q; ra = ptr_q[BW +: AW];
    req_ready_o = 1'b0;
    if (rv_q && rsp_ready_i) rv_d = 1'b0;
    unique case (st_q)
      S_CLEAR: begin
        we = 1'b1; wa = clr_q; wd = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(NWORDS - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = !rv_q;
        if (req_valid_i && !rv_q) begin
          op_d = req_i.op; cnt_d = req_i.n_pages; fa_d = req_i.free_address;
          rsp_d = '0;
          if (req_i.op == OP_ALLOC) begin
            if (req_i.n_pages == '0) begin
              rsp_d.status = ST_ZERO; st_d = S_DONE;
            end else begin
              ptr_d = IW'(hint_q); run_d = '0; st_d = S_SRD;
            end
          end else st_d = S_FCHK;
        end
      end
      S_SRD: begin
        if (ptr_q >= eff) begin
          rsp_d.status = ST_NO_SPACE; st_d = S_DONE;
        end else st_d = S_SCAN;
      end
      S_SCAN: begin
        if (bit_used) run_d = '0;
        else begin
          if (run_q == '0) first_d = ptr_q;
          run_d = run_q + IW'(1);
        end
        ptr_d = ptr_q + IW'(1);
        if (!bit_used && (run_q + IW'(1)) == IW'(cnt_q)) begin
          ptr_d = (run_q == '0) ? ptr_q : first_q;
          end_d = ptr_q + IW'(1);
          st_d = S_MRD;
        end else st_d = S_SRD;
      end
      S_MRD: st_d = S_MARK;
      S_MARK: begin
        we = 1'b1; wd = rd_q; wd[ptr_q[BW-1:0]] = 1'b1;
        ptr_d = ptr_q + IW'(1);
        if (ptr_d == end_q) begin
          used_d = used_sum[13] ? 13'h1FFF : used_sum[12:0];
          if (IW'(hint_q) >= first_q) begin
            ptr_d = end_q; st_d = S_HRD;
          end else st_d = S_ADDR;
        end else st_d = S_MRD;
      end
      S_HRD: begin
        if (ptr_q >= eff) begin
          hint_d = 13'(eff); st_d = S_ADDR;
        end else st_d = S_HSCAN;
      end
      S_HSCAN: begin
        if (!bit_used) begin
          hint_d = 13'(ptr_q); st_d = S_ADDR;
        end else begin
          ptr_d = ptr_q + IW'(1); st_d = S_HRD;
        end
      end
      S_ADDR: begin
        rsp_d.status = ST_OK;
        rsp_d.page_index = 12'(first_q);
        rsp_d.address = base_q + (48'(first_q) << PW);
        st_d = S_DONE;
      end
      S_FCHK: begin
        if (fa_q[PW-1:0] != '0) begin
          rsp_d.status = ST_UNALIGN; st_d = S_DONE;
        end else if (cnt_q == '0) begin
          rsp_d.status = ST_ZERO; st_d = S_DONE;
        end else if (fa_q < base_q) begin
          rsp_d.status = ST_BELOW; st_d = S_DONE;
        end else if ((sp + 48'(cnt_q)) > 48'(eff)) begin
          rsp_d.status = ST_BEYOND; st_d = S_DONE;
        end else begin
          ptr_d = IW'(sp); first_d = IW'(sp); end_d = IW'(sp) + IW'(cnt_q);
          st_d = S_FRD;
        end
      end
      S_FRD: st_d = S_FREE;
      S_FREE: begin
        we = 1'b1; wd = rd_q; wd[ptr_q[BW-1:0]] = 1'b0;
        ptr_d = ptr_q + IW'(1);
        if (ptr_d == end_q) begin
          if (IW'(hint_q) > first_q) hint_d = 13'(first_q);
          used_d = (used_q > cnt_q) ? used_q - cnt_q : '0;
          rsp_d.status = ST_OK;
          rsp_d.page_index = 12'(first_q);
          st_d = S_DONE;
        end else st_d = S_FRD;
      end
      S_DONE: begin
        rsp_d.allocated_count = used_q;
        rv_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR; hint_q <= '0; used_q <= '0; rv_q <= 1'b0; clr_q <= '0;
      ptr_q <= '0; run_q <= '0;
    end else begin
      st_q <= st_d; hint_q <= hint_d; used_q <= used_d; rv_q <= rv_d; clr_q <= clr_d;
      ptr_q <= ptr_d; run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d; end_q <= end_d; cnt_q <= cnt_d; op_q <= op_d;
    fa_q <= fa_d; rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  `BPA_ASSERT(a_ready_idle, req_ready_o |-> (st_q == S_IDLE && !rv_q), "ready outside idle")
  `BPA_ASSERT_NEXT(a_done_valid, st_q == S_DONE, rv_q, "result lost")
  `BPA_ASSERT(a_ok_addr_zero_free,
    (rv_q && op_q == OP_FREE) |-> (rsp_q.address == '0), "free with address")
  `BPA_ASSERT_NEXT(a_hold, rv_q && !rsp_ready_i, rv_q && $stable(rsp_q), "result dropped")

endmodule
